// ===== src/eavt_pkg.sv =====
// ============================================================================
// eavt_pkg
// Shared types and constants of the encoder angle and velocity tracker:
// field widths, register indexes, operation codes and the command and
// status bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package eavt_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int CNT_W    = 16;
    localparam int REV_W    = 32;
    localparam int FIX_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;
    localparam int OUT_W    = CNT_W + REV_W + 3 * FIX_W;

    // Magnitude operand of the scaling multiply and its accumulator
    localparam int MAG_W    = 50;
    localparam int LO_W     = 24;
    localparam int HI_W     = MAG_W - LO_W;
    localparam int PH_W     = HI_W + 32;
    localparam int ACC_W    = PH_W + LO_W;

    // Saturation limits of the signed 48-bit results and the signed 32-bit revolution count
    localparam logic [FIX_W-1:0] FIX_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [FIX_W-1:0] FIX_MIN = 48'h8000_0000_0000;
    localparam logic [REV_W-1:0] REV_MAX = 32'h7FFF_FFFF;
    localparam logic [REV_W-1:0] REV_MIN = 32'h8000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIANS_PER_TICK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_PERIOD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_RADIAN = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_COUNTS_PER_REV    = 16'd4096;
    localparam logic [31:0] RST_RADIANS_PER_TICK  = 32'd411775;
    localparam logic [31:0] RST_INVERSE_PERIOD    = 32'd6553600;
    localparam logic [15:0] RST_METERS_PER_RADIAN = 16'd6554;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_POS     = 2'd0,
        OP_POS_VEL = 2'd1,
        OP_REZERO  = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // Destination of a scaled product
    typedef enum logic [1:0] {
        DEST_ANGLE = 2'd0,
        DEST_AVEL  = 2'd1,
        DEST_LVEL  = 2'd2
    } t_dest;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  load;
        logic  div_step;
        logic  rev_upd;
        logic  mul_rev;
        logic  ld_ticks;
        logic  mul_lo;
        logic  mul_hi;
        logic  combine;
        logic  round;
        logic  store;
        logic  ld_diff;
        logic  ld_lin;
        logic  clear;
        logic  out_load;
        t_dest dest;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_op  op;
        logic cpr_zero;
    } t_status;

endpackage

`default_nettype wire

// ===== src/eavt_ctrl.sv =====
// ============================================================================
// eavt_ctrl
// Sequencer of the tracker: steps one item through the division, the
// revolution update and up to three scaled multiplies (or the rezero
// clear), then hands the result to the output register.
// ============================================================================
`default_nettype none

module eavt_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  wire eavt_pkg::t_status i_status,
    output eavt_pkg::t_cmd  o_cmd
);
    import eavt_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_DECODE = 15'h0002,
        S_DIV    = 15'h0004,
        S_REV    = 15'h0008,
        S_TMUL   = 15'h0010,
        S_TICKS  = 15'h0020,
        S_MLO    = 15'h0040,
        S_MHI    = 15'h0080,
        S_MCOMB  = 15'h0100,
        S_MRND   = 15'h0200,
        S_MSTORE = 15'h0400,
        S_DIFF   = 15'h0800,
        S_LIN    = 15'h1000,
        S_CLEAR  = 15'h2000,
        S_DONE   = 15'h4000
    } t_state;

    t_state      r_state, n_state;
    t_dest       r_dest, n_dest;
    logic [3:0]  r_div_cnt, n_div_cnt;
    logic        r_out_valid, n_out_valid;
    logic        w_out_load;

    // Next state and command decode
    always_comb begin
        n_state   = r_state;
        n_dest    = r_dest;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        o_cmd.dest = r_dest;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_div_cnt = '0;
                unique case (i_status.op)
                    OP_REZERO: n_state = S_CLEAR;
                    OP_NONE:   n_state = S_DONE;
                    default: begin
                        n_state = i_status.cpr_zero ? S_REV : S_DIV;
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt = r_div_cnt + 4'd1;
                if (r_div_cnt == 4'hF) begin
                    n_state = S_REV;
                end
            end
            S_REV: begin
                o_cmd.rev_upd = 1'b1;
                n_state = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.mul_rev = 1'b1;
                n_state = S_TICKS;
            end
            S_TICKS: begin
                o_cmd.ld_ticks = 1'b1;
                n_dest  = DEST_ANGLE;
                n_state = S_MLO;
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_MCOMB;
            end
            S_MCOMB: begin
                o_cmd.combine = 1'b1;
                n_state = S_MRND;
            end
            S_MRND: begin
                o_cmd.round = 1'b1;
                n_state = S_MSTORE;
            end
            S_MSTORE: begin
                o_cmd.store = 1'b1;
                unique case (r_dest)
                    DEST_ANGLE: begin
                        n_state = (i_status.op == OP_POS_VEL) ? S_DIFF : S_DONE;
                    end
                    DEST_AVEL: n_state = S_LIN;
                    default:   n_state = S_DONE;
                endcase
            end
            S_DIFF: begin
                o_cmd.ld_diff = 1'b1;
                n_dest  = DEST_AVEL;
                n_state = S_MLO;
            end
            S_LIN: begin
                o_cmd.ld_lin = 1'b1;
                n_dest  = DEST_LVEL;
                n_state = S_MLO;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Wait until the output register is free or being emptied.
                w_out_load = !r_out_valid || i_out_ready;
                o_cmd.out_load = w_out_load;
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dest      <= DEST_ANGLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dest      <= n_dest;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/eavt_dpath.sv =====
// ============================================================================
// eavt_dpath
// Datapath of the tracker: configuration registers, tracking state, a
// radix-2 restoring divider, one shared 32x32 multiplier with a wide
// accumulator for the scaled products, and the output register.
// ============================================================================
`default_nettype none

module eavt_dpath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [eavt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [eavt_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire [eavt_pkg::OP_W-1:0]     i_op,
    input  wire [eavt_pkg::CNT_W-1:0]    i_count,
    input  wire eavt_pkg::t_cmd          i_cmd,
    output eavt_pkg::t_status            o_status,
    output logic [eavt_pkg::OUT_W-1:0]   o_result
);
    import eavt_pkg::*;

    // Configuration
    logic [15:0]       r_cpr;
    logic [31:0]       r_rpt;
    logic [31:0]       r_ip;
    logic [15:0]       r_mpr;

    // Tracking state
    logic [REV_W-1:0]  r_rev;
    logic [FIX_W-1:0]  r_cur;
    logic [FIX_W-1:0]  r_prev;
    logic [FIX_W-1:0]  r_avel;
    logic [FIX_W-1:0]  r_lvel;

    // Per-item working registers
    t_op               r_op;
    logic [CNT_W-1:0]  r_wb;
    logic              r_cneg;
    logic [15:0]       r_num;
    logic [15:0]       r_rem;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;
    logic [31:0]       r_b;
    logic              r_shift16;
    logic [PH_W-1:0]   r_ph;
    logic [ACC_W-1:0]  r_acc;
    logic [OUT_W-1:0]  r_out;

    // Divider step
    logic [16:0]       w_trial;
    logic              w_ge;
    // Revolution update
    logic [16:0]       w_q;
    logic [16:0]       w_r;
    logic [33:0]       w_sum;
    logic [REV_W-1:0]  w_rev_sat;
    // Shared multiplier
    logic [31:0]       w_rev_abs;
    logic [31:0]       w_mul_a;
    logic [31:0]       w_mul_b;
    logic [63:0]       w_prod;
    // Operand loads
    logic [48:0]       w_ticks;
    logic [48:0]       w_ticks_abs;
    logic [48:0]       w_diff;
    logic [48:0]       w_diff_abs;
    logic [FIX_W-1:0]  w_avel_abs;
    // Scaling, rounding and saturation
    logic [ACC_W-1:0]  w_rnd;
    logic [ACC_W-1:0]  w_q_sh;
    logic              w_sat;
    logic [FIX_W-1:0]  w_scaled;

    // One restoring division step on the sample magnitude
    always_comb begin
        w_trial = {r_rem, r_num[15]};
        w_ge    = (w_trial >= {1'b0, r_cpr});
    end

    // Signed quotient and remainder, then saturating revolution sum
    always_comb begin
        w_q = r_cneg ? (17'd0 - {1'b0, r_num}) : {1'b0, r_num};
        w_r = r_cneg ? (17'd0 - {1'b0, r_rem}) : {1'b0, r_rem};
        if (r_cpr == 16'd0) begin
            w_q = '0;
            w_r = {r_wb[CNT_W-1], r_wb};
        end
        w_sum = {{2{r_rev[REV_W-1]}}, r_rev} + {{17{w_q[16]}}, w_q};
        if (!w_sum[33] && (w_sum[32] || w_sum[31])) begin
            w_rev_sat = REV_MAX;
        end else if (w_sum[33] && !(w_sum[32] && w_sum[31])) begin
            w_rev_sat = REV_MIN;
        end else begin
            w_rev_sat = w_sum[REV_W-1:0];
        end
    end

    // Shared multiplier operand selection
    always_comb begin
        w_rev_abs = r_rev[REV_W-1] ? (32'd0 - r_rev) : r_rev;
        if (i_cmd.mul_rev) begin
            w_mul_a = w_rev_abs;
            w_mul_b = {16'd0, r_cpr};
        end else if (i_cmd.mul_hi) begin
            w_mul_a = {{(32-HI_W){1'b0}}, r_mag[MAG_W-1:LO_W]};
            w_mul_b = r_b;
        end else begin
            w_mul_a = {{(32-LO_W){1'b0}}, r_mag[LO_W-1:0]};
            w_mul_b = r_b;
        end
        w_prod = w_mul_a * w_mul_b;
    end

    // Signed operands of the scaled multiplies and their magnitudes
    always_comb begin
        w_ticks = r_rev[REV_W-1] ? (49'd0 - {2'b00, r_ph[46:0]}) : {2'b00, r_ph[46:0]};
        w_ticks = w_ticks + {{33{r_wb[CNT_W-1]}}, r_wb};
        w_ticks_abs = w_ticks[48] ? (49'd0 - w_ticks) : w_ticks;
        w_diff = {r_cur[FIX_W-1], r_cur} - {r_prev[FIX_W-1], r_prev};
        w_diff_abs = w_diff[48] ? (49'd0 - w_diff) : w_diff;
        w_avel_abs = r_avel[FIX_W-1] ? (48'd0 - r_avel) : r_avel;
    end

    // Floor shift of the signed product, then saturation to 48 bits
    always_comb begin
        w_rnd  = r_shift16 ? ACC_W'(16'hFFFF) : ACC_W'(16'h0FFF);
        w_q_sh = r_shift16 ? (r_acc >> 16) : (r_acc >> 12);
        w_sat  = |w_q_sh[ACC_W-1:FIX_W-1];
        if (w_sat) begin
            w_scaled = r_neg ? FIX_MIN : FIX_MAX;
        end else begin
            w_scaled = r_neg ? (48'd0 - w_q_sh[FIX_W-1:0]) : w_q_sh[FIX_W-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr <= RST_COUNTS_PER_REV;
            r_rpt <= RST_RADIANS_PER_TICK;
            r_ip  <= RST_INVERSE_PERIOD;
            r_mpr <= RST_METERS_PER_RADIAN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_COUNTS_PER_REV:    r_cpr <= i_cfg_wdata[15:0];
                CFG_RADIANS_PER_TICK:  r_rpt <= i_cfg_wdata;
                CFG_INVERSE_PERIOD:    r_ip  <= i_cfg_wdata;
                CFG_METERS_PER_RADIAN: r_mpr <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev  <= '0;
            r_cur  <= '0;
            r_prev <= '0;
            r_avel <= '0;
            r_lvel <= '0;
            r_op   <= OP_POS;
        end else begin
            if (i_cmd.load) begin
                r_op <= t_op'(i_op);
            end
            if (i_cmd.clear) begin
                r_rev  <= '0;
                r_cur  <= '0;
                r_prev <= '0;
                r_avel <= '0;
                r_lvel <= '0;
            end
            if (i_cmd.rev_upd) begin
                r_rev <= w_rev_sat;
            end
            if (i_cmd.ld_diff) begin
                r_prev <= r_cur;
            end
            if (i_cmd.store) begin
                unique case (i_cmd.dest)
                    DEST_ANGLE: r_cur  <= w_scaled;
                    DEST_AVEL:  r_avel <= w_scaled;
                    default:    r_lvel <= w_scaled;
                endcase
            end
        end
    end

    // Working registers of the divider and the scaled multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wb   <= i_count;
            r_cneg <= i_count[CNT_W-1];
            r_num  <= i_count[CNT_W-1] ? (16'd0 - i_count) : i_count;
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? 16'(w_trial - {1'b0, r_cpr}) : w_trial[15:0];
            r_num <= {r_num[14:0], w_ge};
        end
        if (i_cmd.rev_upd) begin
            r_wb <= w_r[CNT_W-1:0];
        end
        if (i_cmd.clear) begin
            r_wb <= '0;
        end
        if (i_cmd.mul_rev || i_cmd.mul_hi) begin
            r_ph <= w_prod[PH_W-1:0];
        end
        if (i_cmd.ld_ticks) begin
            r_mag     <= {1'b0, w_ticks_abs};
            r_neg     <= w_ticks[48];
            r_b       <= r_rpt;
            r_shift16 <= 1'b0;
        end
        if (i_cmd.ld_diff) begin
            r_mag     <= {1'b0, w_diff_abs};
            r_neg     <= w_diff[48];
            r_b       <= r_ip;
            r_shift16 <= 1'b1;
        end
        if (i_cmd.ld_lin) begin
            r_mag     <= {2'b00, w_avel_abs};
            r_neg     <= r_avel[FIX_W-1];
            r_b       <= {16'd0, r_mpr};
            r_shift16 <= 1'b1;
        end
        if (i_cmd.mul_lo) begin
            r_acc <= {{(ACC_W-64){1'b0}}, w_prod};
        end
        if (i_cmd.combine) begin
            r_acc <= {r_ph, {LO_W{1'b0}}} + r_acc;
        end
        if (i_cmd.round && r_neg) begin
            r_acc <= r_acc + w_rnd;
        end
        if (i_cmd.out_load) begin
            r_out <= {r_lvel, r_avel, r_cur, r_rev, r_wb};
        end
    end

    assign o_status.op       = r_op;
    assign o_status.cpr_zero = (r_cpr == 16'd0);
    assign o_result          = r_out;

endmodule

`default_nettype wire

// ===== src/encoder_angle_velocity_tracker.sv =====
// ============================================================================
// encoder_angle_velocity_tracker
// Quadrature counter sample to revolutions, angle and velocities.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser: operation; tdata: count_value
//  m_axis    out        tdata: writeback, revolutions, angle, ang. vel, lin. vel
//  i_cfg_*   in         register write: index, 32-bit data
//
// One item is worked on at a time. A position update runs the bit-serial
// divider, the revolution update and one scaled multiply on the shared
// multiplier (low part, high part, combine, round, store); a velocity update
// adds two more scaled multiplies, and rezero only clears the state. With
// counts per revolution at zero the division is skipped. The input is ready
// again as the result appears, so the next transfer can be taken while it waits.
// Reset is synchronous and active low; it restores the register defaults
// and zeroes all tracking state. The result waits in an output register,
// so a stalled output only holds the next result at its final step.
// ============================================================================
`default_nettype none

module encoder_angle_velocity_tracker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Input: tdata = count_value[15:0]; tuser = operation[1:0]
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [eavt_pkg::CNT_W-1:0]      s_axis_tdata,
    input  wire [eavt_pkg::OP_W-1:0]       s_axis_tuser,
    // Output: tdata = counter_writeback[15:0], revolution_count[47:16],
    // angle[95:48], angular_velocity[143:96], linear_velocity[191:144]
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [eavt_pkg::OUT_W-1:0]     m_axis_tdata,
    // Configuration write port
    input  wire                            i_cfg_wr_en,
    input  wire [eavt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [eavt_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import eavt_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    eavt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and state
    eavt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_count     (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (m_axis_tdata)
    );

    // A transfer in starts work, so the input is not ready the cycle after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready while an item is in work");

    // A finished result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register loaded while holding a result");

    // The shared multiplier serves one request at a time.
    a_mul_one_user: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.mul_lo, w_cmd.mul_hi, w_cmd.mul_rev}))
        else $error("multiplier requested by more than one step");

    // Division steps, stores and clears are never issued while the input is ready.
    a_no_step_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(w_cmd.div_step || w_cmd.store || w_cmd.clear))
        else $error("datapath step issued while idle");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Encoder angle and velocity tracker testbench
// Drives counter samples through the input stream and compares every result
// with a local model of the tracker. The model covers the revolution split,
// the angle and velocity scaling and the saturation rules. The run has a
// directed start at the register defaults and extremes and a sequence that drives the
// angle into saturation. Random traffic follows under several register
// settings, with idle bursts on both sides, a long output hold-off and a
// final stretch at full rate.
// ============================================================================

module testbench;
    import eavt_pkg::*;

    // Cycles to let pass after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 60;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;

    localparam longint ANGLE_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ANGLE_LO = -ANGLE_HI - 1;

    // One result item of the tracker.
    typedef struct {
        logic [CNT_W-1:0] wb;
        logic [REV_W-1:0] rev;
        logic [FIX_W-1:0] angle;
        logic [FIX_W-1:0] avel;
        logic [FIX_W-1:0] lvel;
    } t_track_out;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [CNT_W-1:0]     s_axis_tdata  = '0;
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;

    // Register copies of the model.
    logic [15:0] cfg_cpr = RST_COUNTS_PER_REV;
    logic [31:0] cfg_rpt = RST_RADIANS_PER_TICK;
    logic [31:0] cfg_ip  = RST_INVERSE_PERIOD;
    logic [15:0] cfg_mpr = RST_METERS_PER_RADIAN;

    // Tracking state of the model.
    int     rev_total  = 0;
    longint angle_now  = 0;
    longint angle_prev = 0;
    longint avel_last  = 0;
    longint lvel_last  = 0;

    t_track_out predicted_outputs[$];

    bit tx_idle_on  = 1'b0;
    bit rx_idle_on  = 1'b0;
    int rx_hold_len = 0;
    int idle_cycles = 0;

    int samples_sent     = 0;
    int results_checked  = 0;
    int mismatches       = 0;
    int settings_applied = 0;

    encoder_angle_velocity_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // count_value[15:0]
        .s_axis_tuser  (s_axis_tuser),   // operation[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // counter_writeback, revolution_count, angle, angular_velocity,
        // linear_velocity, from the lowest bit up
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Exact product, floor of the scaling shift, then saturation to 48 bits.
    function automatic longint scale_sat(input longint a, input logic [31:0] b, input int s);
        logic signed [127:0] prod;
        prod = $signed({{64{a[63]}}, a}) * $signed({96'd0, b});
        prod = prod >>> s;
        if (prod > ANGLE_HI)
            return ANGLE_HI;
        if (prod < ANGLE_LO)
            return ANGLE_LO;
        return longint'(prod);
    endfunction

    // Advances the model by one sample and returns the result it causes.
    function automatic t_track_out predict_output(input t_op op, input logic [15:0] count);
        t_track_out r;
        int         c;
        int         q;
        int         rem;
        int         d;
        longint     sum;
        longint     ticks;
        longint     diff;
        c    = $signed(count);
        r.wb = count;
        if (op == OP_REZERO) begin
            rev_total  = 0;
            angle_now  = 0;
            angle_prev = 0;
            avel_last  = 0;
            lvel_last  = 0;
            r.wb       = '0;
        end else if (op != OP_NONE) begin
            q   = 0;
            rem = c;
            // With zero counts per revolution the whole sample is the remainder.
            if (cfg_cpr != 16'd0) begin
                d   = cfg_cpr;
                q   = c / d;
                rem = c % d;
            end
            sum = longint'(rev_total) + q;
            if (sum > longint'($signed(REV_MAX)))
                sum = longint'($signed(REV_MAX));
            if (sum < longint'($signed(REV_MIN)))
                sum = longint'($signed(REV_MIN));
            rev_total = int'(sum);
            r.wb      = rem[15:0];
            ticks     = longint'(rev_total) * longint'(cfg_cpr) + rem;
            angle_now = scale_sat(ticks, cfg_rpt, 12);
            if (op == OP_POS_VEL) begin
                diff       = angle_now - angle_prev;
                avel_last  = scale_sat(diff, cfg_ip, 16);
                lvel_last  = scale_sat(avel_last, {16'd0, cfg_mpr}, 16);
                angle_prev = angle_now;
            end
        end
        r.rev   = rev_total;
        r.angle = angle_now[47:0];
        r.avel  = avel_last[47:0];
        r.lvel  = lvel_last[47:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [47:0] want,
                                        input logic [47:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    // Offers one sample and waits for its transfer; valid stays high afterwards.
    task automatic send_sample(input t_op op, input logic [15:0] count);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= count;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted_outputs.push_back(predict_output(op, count));
        samples_sent++;
    endtask

    // Stops offering samples until every predicted result has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers back to back; the block must be idle.
    task automatic apply_settings(input logic [15:0] cpr, input logic [31:0] rpt,
                                  input logic [31:0] ip, input logic [15:0] mpr);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_COUNTS_PER_REV;
        i_cfg_wdata <= {16'd0, cpr};
        @(posedge i_clk);
        i_cfg_index <= CFG_RADIANS_PER_TICK;
        i_cfg_wdata <= rpt;
        @(posedge i_clk);
        i_cfg_index <= CFG_INVERSE_PERIOD;
        i_cfg_wdata <= ip;
        @(posedge i_clk);
        i_cfg_index <= CFG_METERS_PER_RADIAN;
        i_cfg_wdata <= {16'd0, mpr};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_cpr = cpr;
        cfg_rpt = rpt;
        cfg_ip  = ip;
        cfg_mpr = mpr;
        settings_applied++;
    endtask

    function automatic t_op random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_POS;
        if (r < 88)
            return OP_POS_VEL;
        if (r < 94)
            return OP_REZERO;
        return OP_NONE;
    endfunction

    function automatic logic [15:0] random_count();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    // Random register setting, biased toward small counts per revolution.
    task automatic apply_random_settings();
        logic [15:0] cpr;
        logic [31:0] rpt;
        logic [31:0] ip;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: cpr = 16'($urandom_range(1, 16));
            4, 5:       cpr = 16'($urandom_range(1, 4096));
            6:          cpr = 16'hFFFF;
            7:          cpr = 16'd0;
            default:    cpr = 16'($urandom());
        endcase
        rpt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000) : $urandom();
        ip  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70000) : $urandom();
        apply_settings(cpr, rpt, ip, 16'($urandom()));
    endtask

    // Register defaults after reset, every operation and the sample extremes.
    task automatic test_reset_defaults();
        send_sample(OP_POS,     16'h0000);
        send_sample(OP_POS,     16'h7FFF);
        send_sample(OP_POS,     16'h8000);
        send_sample(OP_POS_VEL, 16'd4095);
        send_sample(OP_POS_VEL, 16'hF000);
        send_sample(OP_NONE,    16'h1234);
        send_sample(OP_POS_VEL, 16'h0001);
        send_sample(OP_REZERO,  16'h5A5A);
        send_sample(OP_POS_VEL, 16'hFFFF);
        wait_drained();
    endtask

    // Zero and full-scale register values, including the skipped division.
    task automatic test_register_extremes();
        apply_settings(16'd0, 32'hFFFF_FFFF, 32'd1, 16'hFFFF);
        send_sample(OP_POS,     16'h7FFF);
        send_sample(OP_POS_VEL, 16'h8000);
        wait_drained();
        apply_settings(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_sample(OP_POS_VEL, 16'h7FFF);
        send_sample(OP_POS_VEL, 16'h8000);
        send_sample(OP_POS_VEL, 16'h7FFF);
        wait_drained();
        apply_settings(16'hFFFF, 32'd0, 32'd0, 16'd0);
        send_sample(OP_POS_VEL, 16'h7FFF);
        send_sample(OP_POS_VEL, 16'h8000);
        wait_drained();
    endtask

    // Builds a large revolution total in each direction, then widens the
    // revolution so that the angle saturates.
    task automatic test_angle_saturation();
        apply_settings(16'd1, 32'd1, RST_INVERSE_PERIOD, RST_METERS_PER_RADIAN);
        repeat (60) send_sample(OP_POS, 16'h7FFF - 16'($urandom_range(0, 255)));
        wait_drained();
        apply_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_sample(OP_POS_VEL, random_count());
        send_sample(OP_POS_VEL, random_count());
        send_sample(OP_REZERO,  random_count());
        wait_drained();
        apply_settings(16'd1, 32'd1, RST_INVERSE_PERIOD, RST_METERS_PER_RADIAN);
        repeat (60) send_sample(OP_POS, 16'h8000 + 16'($urandom_range(0, 255)));
        wait_drained();
        apply_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_sample(OP_POS_VEL, random_count());
        send_sample(OP_POS_VEL, random_count());
        wait_drained();
    endtask

    // Random samples under a series of random register settings.
    task automatic test_random_traffic();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (8) begin
            apply_random_settings();
            repeat (130) send_sample(random_op(), random_count());
            wait_drained();
        end
    endtask

    // The output holds off for a long stretch while samples keep coming, then
    // the sender pauses until all results are in before it goes on.
    task automatic test_output_holdoff();
        tx_idle_on  = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        repeat (12) send_sample(random_op(), random_count());
        wait_drained();
        repeat (10) send_sample(random_op(), random_count());
        wait_drained();
    endtask

    // Full rate on both sides to finish the run.
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_random_settings();
        repeat (100) send_sample(random_op(), random_count());
        wait_drained();
    endtask

    // Output ready: random stall bursts, or a long hold-off on request.
    initial begin : output_ready_driver
        int burst;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                burst = $urandom_range(1, 19);
                repeat (burst) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin : result_checker
        t_track_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_outputs.size() == 0) begin
                $error("Result transfer with no prediction waiting: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = predicted_outputs.pop_front();
                check_field("counter_writeback", 48'(want.wb),  48'(m_axis_tdata[15:0]));
                check_field("revolution_count",  48'(want.rev), 48'(m_axis_tdata[47:16]));
                check_field("angle",             want.angle,    m_axis_tdata[95:48]);
                check_field("angular_velocity",  want.avel,     m_axis_tdata[143:96]);
                check_field("linear_velocity",   want.lvel,     m_axis_tdata[191:144]);
                results_checked++;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_extremes();
        test_angle_saturation();
        test_random_traffic();
        test_output_holdoff();
        test_full_rate();
        $display("Run covered %0d samples and %0d checked results under %0d register settings,",
                 samples_sent, results_checked, settings_applied);
        $display("with idle bursts, a %0d-cycle output hold-off and a full-rate finish.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
